FILE: rtl/core/wgmm_pkg.sv
// Package for the windowed Gaussian motion mask: sequencer states, register indexes, gray weights.
`timescale 1ns / 1ps
`default_nettype none
package wgmm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_ACC,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_OUT
    } t_state;

    localparam logic [1:0] REG_HISTORY_SIZE = 2'd0;
    localparam logic [1:0] REG_DEV_THRESH   = 2'd1;
    localparam logic [1:0] REG_FRAME_PIXELS = 2'd2;

    localparam logic [5:0]  HISTORY_RESET = 6'd5;
    localparam logic [4:0]  THRESH_RESET  = 5'd2;
    localparam logic [16:0] FRAME_RESET   = 17'd65536;

    localparam logic [12:0] W_RED   = 13'd4899;
    localparam logic [13:0] W_GREEN = 14'd9617;
    localparam logic [10:0] W_BLUE  = 11'd1868;
    localparam logic [21:0] GRAY_RND = 22'd8192;

    localparam logic [7:0] MASK_ON  = 8'd255;
    localparam logic [7:0] MASK_OFF = 8'd0;

endpackage
`default_nettype wire

FILE: rtl/core/windowed_gaussian_motion_mask.sv
// Windowed single-Gaussian motion mask: gray conversion, per-pixel history memory, variance test.
// Words are handled one at a time: a new word is accepted only in the idle state, once the
// previous result has been loaded into the output register, which waits for the sink.
// The slot accumulation loop reads one history entry per cycle; in the first frame, when no
// statistics are needed, the loop and the multiply steps are skipped.
// Reset: synchronous, active low; control and configuration registers return to their defaults
// and the next frame refills every history slot, so the history memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module windowed_gaussian_motion_mask #(
    parameter int HISTORY_MAX = 32,
    parameter int PIXELS_MAX  = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // mask_value [7:0]
    output logic             o_m_axis_tlast
);
    import wgmm_pkg::*;

    localparam int HW    = $clog2(HISTORY_MAX + 1);
    localparam int SW    = (HISTORY_MAX > 1) ? $clog2(HISTORY_MAX) : 1;
    localparam int PIXW  = $clog2(PIXELS_MAX);
    localparam int PW    = PIXW + 1;
    localparam int SUMW  = $clog2(HISTORY_MAX * 255 + 1);
    localparam int QW    = $clog2(HISTORY_MAX * 65025 + 1);
    localparam int SPW   = (HW + QW > 2 * SUMW) ? HW + QW : 2 * SUMW;
    localparam int PRW   = SPW + 10;
    localparam int WORDW = HISTORY_MAX * 8;

    // Configuration and frame state.
    logic [5:0]      r_hist;
    logic [4:0]      r_thresh;
    logic [16:0]     r_frame;
    logic [SW-1:0]   r_oldest;
    logic [PIXW-1:0] r_pix;
    logic            r_filled;

    t_state r_state, n_state;

    // Item datapath.
    logic [7:0]       r_gray;
    logic [PIXW-1:0]  r_pos;
    logic             r_item_filled;
    logic             r_item_last;
    logic [WORDW-1:0] r_rdata;
    logic [WORDW-1:0] r_word;
    logic [HW-1:0]    r_k;
    logic [SUMW-1:0]  r_s;
    logic [QW-1:0]    r_q;
    logic [SUMW-1:0]  r_dev;
    logic [SPW-1:0]   r_hq;
    logic [SPW-1:0]   r_ss;
    logic [9:0]       r_t2;
    logic [2*SUMW-1:0] r_dd;
    logic [SPW-1:0]   r_spread;
    logic [PRW-1:0]   r_prod;

    logic             r_out_valid;
    logic [7:0]       r_mask;
    logic             r_last;

    logic [WORDW-1:0] mem [PIXELS_MAX];

    // Effective sizes.
    logic [HW-1:0] h_eff;
    logic [PW-1:0] n_eff;
    always_comb begin
        if (r_hist == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_hist) > 32'(HISTORY_MAX)) begin
            h_eff = HW'(HISTORY_MAX);
        end else begin
            h_eff = HW'(r_hist);
        end
        if (r_frame == '0) begin
            n_eff = PW'(1);
        end else if (32'(r_frame) > 32'(PIXELS_MAX)) begin
            n_eff = PW'(PIXELS_MAX);
        end else begin
            n_eff = PW'(r_frame);
        end
    end

    // Gray conversion of the incoming word.
    logic [21:0] gray_sum;
    assign gray_sum = 22'(W_RED) * 22'(i_s_axis_tdata[23:16])
                    + 22'(W_GREEN) * 22'(i_s_axis_tdata[15:8])
                    + 22'(W_BLUE) * 22'(i_s_axis_tdata[7:0]) + GRAY_RND;

    logic in_acc;
    logic out_load;
    logic out_free;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // New history word: the first frame fills every slot, later frames replace the oldest.
    logic [WORDW-1:0] new_word;
    always_comb begin
        for (int j = 0; j < HISTORY_MAX; j++) begin
            if (!r_item_filled || SW'(j) == r_oldest) begin
                new_word[j*8 +: 8] = r_gray;
            end else begin
                new_word[j*8 +: 8] = r_rdata[j*8 +: 8];
            end
        end
    end

    logic [7:0] acc_v;
    assign acc_v = r_word[{r_k[SW-1:0], 3'b000} +: 8];

    logic acc_done;
    assign acc_done = (r_k == h_eff - HW'(1));

    logic frame_end;
    assign frame_end = (({1'b0, r_pix} + PW'(1)) >= n_eff);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_READ;
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = r_item_filled ? ST_ACC : ST_OUT;
            ST_ACC:    if (acc_done) n_state = ST_MUL1;
            ST_MUL1:   n_state = ST_MUL2;
            ST_MUL2:   n_state = ST_MUL3;
            ST_MUL3:   n_state = ST_OUT;
            ST_OUT:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State-decoded controls.
    always_comb begin
        o_s_axis_tready = 1'b0;
        out_load        = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_OUT:  out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration and frame position. A size change restarts the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist   <= HISTORY_RESET;
            r_thresh <= THRESH_RESET;
            r_frame  <= FRAME_RESET;
            r_oldest <= '0;
            r_pix    <= '0;
            r_filled <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_HISTORY_SIZE: begin
                        if (i_cfg_data[5:0] != r_hist) begin
                            r_hist   <= i_cfg_data[5:0];
                            r_oldest <= '0;
                            r_pix    <= '0;
                            r_filled <= 1'b0;
                        end
                    end
                    REG_DEV_THRESH: r_thresh <= i_cfg_data[4:0];
                    REG_FRAME_PIXELS: begin
                        if (i_cfg_data != r_frame) begin
                            r_frame  <= i_cfg_data;
                            r_oldest <= '0;
                            r_pix    <= '0;
                            r_filled <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end else if (r_state == ST_UPDATE) begin
                if (frame_end) begin
                    r_pix    <= '0;
                    r_filled <= 1'b1;
                    r_oldest <= (HW'(r_oldest) + HW'(1) == h_eff) ? '0 : r_oldest + SW'(1);
                end else begin
                    r_pix <= r_pix + PIXW'(1);
                end
            end
        end
    end

    // History memory: one word holds every slot of a pixel.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            mem[r_pos] <= new_word;
        end
        if (in_acc) begin
            r_rdata <= mem[r_pix];
        end
    end

    // Item datapath.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_gray        <= gray_sum[21:14];
            r_pos         <= r_pix;
            r_item_filled <= r_filled;
        end
        if (r_state == ST_UPDATE) begin
            r_word      <= new_word;
            r_item_last <= frame_end;
            r_k         <= '0;
            r_s         <= '0;
            r_q         <= '0;
        end
        if (r_state == ST_ACC) begin
            r_s <= r_s + SUMW'(acc_v);
            r_q <= r_q + QW'(acc_v) * QW'(acc_v);
            r_k <= r_k + HW'(1);
        end
        if (r_state == ST_MUL1) begin
            if (SUMW'(h_eff) * SUMW'(r_gray) >= r_s) begin
                r_dev <= SUMW'(h_eff) * SUMW'(r_gray) - r_s;
            end else begin
                r_dev <= r_s - SUMW'(h_eff) * SUMW'(r_gray);
            end
            r_hq <= SPW'(SPW'(h_eff) * SPW'(r_q));
            r_ss <= SPW'(SPW'(r_s) * SPW'(r_s));
            r_t2 <= 10'(r_thresh) * 10'(r_thresh);
        end
        if (r_state == ST_MUL2) begin
            r_dd     <= (2*SUMW)'(r_dev) * (2*SUMW)'(r_dev);
            r_spread <= r_hq - r_ss;
        end
        if (r_state == ST_MUL3) begin
            r_prod <= PRW'(PRW'(r_t2) * PRW'(r_spread));
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_mask <= (r_item_filled && (PRW'(r_dd) < r_prod)) ? MASK_ON : MASK_OFF;
            r_last <= r_item_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_mask;
    assign o_m_axis_tlast  = r_last;

`ifndef SYNTHESIS
    a_oldest_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HW'(r_oldest) < h_eff) else $error("oldest slot outside the window");
    a_pix_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pix} < n_eff) || i_cfg_we || $past(i_cfg_we))
        else $error("pixel index beyond frame");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_m_axis_tvalid) else $error("loaded result not shown");
`endif

endmodule
`default_nettype wire
